[hdl/arprr_pkg.sv]
// Shared types and constants for the round-robin ARP binding table.
package arprr_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int KIND_W      = 2;

  // Operation codes carried in the input tuser field; code 3 means nothing.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_PURGE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

[hdl/arprr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module arprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/arp_cache_round_robin.sv]
// Top level of the round-robin IPv4-to-MAC binding table.
//
// The table holds ENTRIES bindings of an IPv4 address and a 48-bit MAC in one
// RAM row each, with a valid bit per slot in flip-flops that reset clears, so
// no clearing pass is needed after reset. Each input item carries an operation
// in s_axis_tuser: insert writes the slot under a round-robin pointer (valid or
// not) and advances the pointer with wrap; lookup searches for an address and
// returns the MAC of the most recently written valid match; purge invalidates
// every valid slot holding a MAC and leaves the pointer alone. Every item gives
// exactly one result item: m_axis_tuser is the hit flag and m_axis_tdata the
// MAC on a lookup hit, both zero otherwise (also for the unused code 3).
// Timing: the block takes one item at a time. Insert and the unused code go
// from idle straight to the finish state, which loads the output register
// once it is free, and the next item is taken back in idle. Lookup and purge
// walk the slots backward from the newest one, one RAM read and one compare
// per cycle through a single shared comparator, and then pass through the
// finish state in the same way; a lookup stops at its first hit. A finished
// result sits in the output register, and the next item is accepted while it
// waits; a later result is held until that one has been taken.
module arp_cache_round_robin #(
  parameter int ENTRIES = arprr_pkg::ENTRIES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // Input items
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // [31:0] ip_addr, [79:32] hw_addr
  input  logic [arprr_pkg::IP_W+arprr_pkg::MAC_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [arprr_pkg::KIND_W-1:0]               s_axis_tuser,
  // Result items
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // [47:0] found_mac
  output logic [arprr_pkg::MAC_W-1:0]                m_axis_tdata,
  // [0] hit
  output logic [0:0]                                 m_axis_tuser
);

  import arprr_pkg::*;

  localparam int AW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int ROW_W = IP_W + MAC_W;

  // Sequencer state
  state_t state;
  state_t state_next;

  // Table state: pointer and valid bits in flip-flops, bindings in RAM
  logic [AW-1:0]      next_slot;
  logic [ENTRIES-1:0] valid;

  // Captured operation and search key
  kind_t              op;
  logic [IP_W-1:0]    key_ip;
  logic [MAC_W-1:0]   key_mac;

  // Scan control: read address, issued-read count, compare stage
  logic [AW-1:0]      addr;
  logic [CW-1:0]      cnt;
  logic               cmp_valid;
  logic               cmp_last;
  logic [AW-1:0]      cmp_idx;

  // Pending result and output register
  logic               res_hit;
  logic [MAC_W-1:0]   res_mac;
  logic               out_valid;
  logic               out_hit;
  logic [MAC_W-1:0]   out_mac;

  // Combinational control
  logic               in_acc;
  logic               out_acc;
  logic               issue;
  logic               load_out;
  logic               ram_we;
  logic [ROW_W-1:0]   ram_rdata;
  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;
  logic [MAC_W-1:0]   cmp_a;
  logic [MAC_W-1:0]   cmp_b;
  logic               match;
  logic               found;
  logic [AW-1:0]      start_addr;
  logic [AW-1:0]      addr_dec;
  logic [AW-1:0]      slot_inc;
  kind_t              in_kind;

  assign in_kind = kind_t'(s_axis_tuser);

  // Binding RAM: row holds {mac, ip}
  arprr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_slot),
    .wdata (s_axis_tdata),
    .re    (issue),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign rd_ip  = ram_rdata[IP_W-1:0];
  assign rd_mac = ram_rdata[ROW_W-1:IP_W];

  // Shared comparator: lookup compares addresses, purge compares MACs
  always_comb begin
    if (op == KIND_LOOKUP) begin
      cmp_a = MAC_W'(rd_ip);
      cmp_b = MAC_W'(key_ip);
    end else begin
      cmp_a = rd_mac;
      cmp_b = key_mac;
    end
  end

  assign match = (state == ST_SCAN) && cmp_valid && valid[cmp_idx] && (cmp_a == cmp_b);
  assign found = match && (op == KIND_LOOKUP);

  // Pointer arithmetic with wrap over ENTRIES slots
  assign start_addr = (next_slot == '0) ? AW'(ENTRIES - 1) : next_slot - AW'(1);
  assign addr_dec   = (addr == '0) ? AW'(ENTRIES - 1) : addr - AW'(1);
  assign slot_inc   = (next_slot == AW'(ENTRIES - 1)) ? '0 : next_slot + AW'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_kind inside {KIND_LOOKUP, KIND_PURGE}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_valid && (found || cmp_last)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SCAN:   issue = (cnt != CW'(ENTRIES));
      ST_FINISH: load_out = !out_valid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = out_valid && m_axis_tready;
  assign ram_we  = in_acc && (in_kind == KIND_INSERT);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_slot <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Insert: claim the slot under the pointer and advance
      if (ram_we) begin
        valid[next_slot] <= 1'b1;
        next_slot        <= slot_inc;
      end
      // Purge: drop every matching slot
      if (match && (op == KIND_PURGE)) begin
        valid[cmp_idx] <= 1'b0;
      end
      if (in_acc) begin
        cmp_valid <= 1'b0;
      end else if (state == ST_SCAN) begin
        cmp_valid <= issue;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op      <= in_kind;
      key_ip  <= s_axis_tdata[IP_W-1:0];
      key_mac <= s_axis_tdata[ROW_W-1:IP_W];
      addr    <= start_addr;
      cnt     <= '0;
      res_hit <= 1'b0;
      res_mac <= '0;
    end
    // Advance the backward walk one slot per cycle
    if (issue) begin
      addr     <= addr_dec;
      cnt      <= cnt + CW'(1);
      cmp_idx  <= addr;
      cmp_last <= (cnt == CW'(ENTRIES - 1));
    end
    // Hold the newest matching binding
    if (found) begin
      res_hit <= 1'b1;
      res_mac <= rd_mac;
    end
    if (load_out) begin
      out_hit <= res_hit;
      out_mac <= res_mac;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_mac;
  assign m_axis_tuser[0] = out_hit;

endmodule
